// ----- rtl/websocket_frame_deframer_defines.svh -----
// Assertion macros used by the WebSocket deframer RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wsfd assertion failed");

// Next-cycle implication, checked outside reset.
`define WSFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wsfd assertion failed");

`endif

// ----- rtl/wsfd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsfd_parser and websocket_frame_deframer.
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;
    localparam int OPC_W    = 4;
    localparam int LEN_W    = 32;

    localparam logic [STATUS_W-1:0] ST_DATA   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOOBIG = 2'd2;

    localparam logic [OPC_W-1:0] OPC_CLOSE = 4'd8;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [LEN_W-1:0] MAX_MSG_RESET = 32'd65536;

    // Register index of max_message_size
    localparam logic REG_MAX_MSG = 1'b0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   payload_byte;
        logic [OPC_W-1:0]    frame_opcode;
        logic                final_fragment;
        logic                last_of_frame;
    } wsfd_result_t;

endpackage

// ----- rtl/wsfd_parser.sv -----
// Frame header parser and payload unmasker: one byte in, at most one result out.
// Depends on wsfd_pkg and websocket_frame_deframer_defines.svh.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module wsfd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [wsfd_pkg::BYTE_W-1:0] in_byte,
    input  logic [wsfd_pkg::LEN_W-1:0]  max_size,
    output logic                        res_valid,
    output wsfd_pkg::wsfd_result_t      res
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic                          fin_reg, fin_next;
    logic [wsfd_pkg::OPC_W-1:0]    opcode_reg, opcode_next;
    logic                          mask_reg, mask_next;
    logic [wsfd_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                          ovf_reg, ovf_next;
    logic [3:0]                    left_reg, left_next;
    logic [31:0]                   key_reg, key_next;
    logic [wsfd_pkg::LEN_W-1:0]    remain_reg, remain_next;
    logic                          halted_reg, halted_next;

    logic                          do_len_done;
    logic                          do_start;
    logic [wsfd_pkg::LEN_W-1:0]    chk_len;
    logic                          chk_ovf;
    logic [wsfd_pkg::LEN_W-1:0]    start_len;

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        halted_next = halted_reg;

        do_len_done = 1'b0;
        do_start    = 1'b0;
        chk_len     = len_reg;
        chk_ovf     = ovf_reg;
        start_len   = len_reg;

        res_valid          = 1'b0;
        res.status         = wsfd_pkg::ST_DATA;
        res.payload_byte   = '0;
        res.frame_opcode   = opcode_reg;
        res.final_fragment = fin_reg;
        res.last_of_frame  = 1'b1;

        if (in_valid && !halted_reg) begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    mask_next = in_byte[7];
                    if (in_byte[6:0] == wsfd_pkg::LEN_EXT16 ||
                        in_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        left_next  = (in_byte[6:0] == wsfd_pkg::LEN_EXT16) ?
                                     wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end else begin
                        chk_len     = {{(wsfd_pkg::LEN_W-7){1'b0}}, in_byte[6:0]};
                        chk_ovf     = 1'b0;
                        len_next    = chk_len;
                        ovf_next    = 1'b0;
                        do_len_done = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    // Big-endian shift in; anything pushed past 32 bits is too large anyway
                    chk_len   = {len_reg[wsfd_pkg::LEN_W-9:0], in_byte};
                    chk_ovf   = ovf_reg | (len_reg[wsfd_pkg::LEN_W-1 -: 8] != 8'd0);
                    len_next  = chk_len;
                    ovf_next  = chk_ovf;
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1) begin
                        do_len_done = 1'b1;
                    end
                end
                PH_MASKKEY: begin
                    key_next  = {key_reg[23:0], in_byte};
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1) begin
                        do_start  = 1'b1;
                        start_len = len_reg;
                    end
                end
                PH_PAYLOAD: begin
                    // Top key byte lines up with the current payload index mod 4
                    res_valid         = 1'b1;
                    res.payload_byte  = in_byte ^ key_reg[31:24];
                    res.last_of_frame = (remain_reg == 32'd1);
                    key_next          = {key_reg[23:0], key_reg[31:24]};
                    remain_next       = remain_reg - 32'd1;
                    if (remain_reg == 32'd1) begin
                        phase_next = PH_HDR0;
                        if (opcode_reg == wsfd_pkg::OPC_CLOSE) begin
                            halted_next = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            if (do_len_done) begin
                if (chk_ovf || (chk_len > max_size)) begin
                    res_valid   = 1'b1;
                    res.status  = wsfd_pkg::ST_TOOBIG;
                    halted_next = 1'b1;
                    phase_next  = PH_HDR0;
                end else begin
                    key_next = '0;
                    if (mask_next) begin
                        left_next  = wsfd_pkg::KEY_BYTES;
                        phase_next = PH_MASKKEY;
                    end else begin
                        do_start  = 1'b1;
                        start_len = chk_len;
                    end
                end
            end

            if (do_start) begin
                if (start_len == '0) begin
                    res_valid  = 1'b1;
                    res.status = wsfd_pkg::ST_EMPTY;
                    phase_next = PH_HDR0;
                    if (opcode_reg == wsfd_pkg::OPC_CLOSE) begin
                        halted_next = 1'b1;
                    end
                end else begin
                    remain_next = start_len;
                    phase_next  = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            left_reg   <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            left_reg   <= left_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            halted_reg <= halted_next;
        end
    end

    `WSFD_ASSERT_NEXT(a_halt_sticks, halted_reg, halted_reg)
    `WSFD_ASSERT_NOW(a_no_result_halted, halted_reg, !res_valid)
    `WSFD_ASSERT_NOW(a_payload_nonzero, phase_reg == PH_PAYLOAD, remain_reg != '0)
    `WSFD_ASSERT_NEXT(a_toobig_halts, res_valid && res.status == wsfd_pkg::ST_TOOBIG, halted_reg)

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: stream ports, APB register, result register.
// Depends on wsfd_pkg and wsfd_parser.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tdata = rx_byte
//  m_       out        m_tvalid/m_tready  m_tdata = payload_byte, m_tuser = status,
//                                         frame_opcode, final_fragment; m_tlast
//  APB      in/out     psel/penable       max_message_size at byte address 0
//
//  One received byte is taken per cycle while s_tready is high; the header parse
//  and unmask run in one pass between the byte port and the result register, so
//  results appear in the cycle after the byte that causes them.
//  A full result register is refilled in the same cycle it drains, so a stall on
//  m_tready only stops input while the held result is not taken.
//  Reset (aresetn low, synchronous) returns the parser to the first header byte,
//  clears the halt and restores max_message_size to 65536.

module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] payload_byte
    output logic [6:0]  m_tuser,    // [1:0] status, [5:2] frame_opcode, [6] final_fragment
    output logic        m_tlast,    // last_of_frame

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [wsfd_pkg::LEN_W-1:0] max_size_reg;
    logic                       out_valid_reg;
    wsfd_pkg::wsfd_result_t     out_reg;

    logic                       in_accept;
    logic                       res_valid;
    wsfd_pkg::wsfd_result_t     res;

    // Accept while the result register is empty or draining this cycle
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    wsfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_accept),
        .in_byte   (s_tdata),
        .max_size  (max_size_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Load a new result or drop the delivered one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.payload_byte;
    assign m_tuser  = {out_reg.final_fragment, out_reg.frame_opcode, out_reg.status};
    assign m_tlast  = out_reg.last_of_frame;

    // APB: single register at address 0, zero-wait
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= wsfd_pkg::MAX_MSG_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == wsfd_pkg::REG_MAX_MSG) begin
            max_size_reg <= pwdata;
        end
    end

    // Low address bits are the byte offset inside the register
    assign prdata = (paddr[2] == wsfd_pkg::REG_MAX_MSG && paddr[1:0] == 2'b00) ?
                    max_size_reg : 32'd0;

endmodule
